// ===== hdl/mtrc_pkg.sv =====
// Shared types and constants for the Modbus TCP response checker.
package mtrc_pkg;

    // Default for the saturating byte counter limit.
    localparam int MAX_PACKET_BYTES_DEF = 511;

    // Packet offsets of the captured bytes.
    localparam int POS_TID_HI = 0;
    localparam int POS_TID_LO = 1;
    localparam int POS_LEN_HI = 4;
    localparam int POS_LEN_LO = 5;
    localparam int POS_FUNC   = 7;
    localparam int POS_BYTE8  = 8;

    // Size thresholds and offsets used by the checks.
    localparam int HEADER_MIN_BYTES = 7;
    localparam int PACKET_MIN_BYTES = 9;
    localparam int LENGTH_OFFSET    = 6;
    localparam int COUNT_OFFSET     = 9;

    // Bit that marks an exception response in the function byte.
    localparam logic [7:0] EXC_FLAG = 8'h80;

    // Result status codes, in order of check priority.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HEADER  = 3'd1,
        ST_INCOMPL = 3'd2,
        ST_EXCEPT  = 3'd3,
        ST_FUNC    = 3'd4,
        ST_LENGTH  = 3'd5,
        ST_ID      = 3'd6,
        ST_COUNT   = 3'd7
    } t_status;

    // One registered input item.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic [7:0]  expected_function;
        logic [15:0] expected_trans_id;
        logic        check_trans_id;
        logic        check_byte_count;
    } t_item;

    // Header fields captured from the current packet.
    typedef struct packed {
        logic [15:0] trans_id;
        logic [15:0] length;
        logic [7:0]  function_code;
        logic [7:0]  byte_eight;
    } t_capture;

endpackage

// ===== hdl/mtrc_in_stage.sv =====
// Input register stage with valid/stall handshake.
module mtrc_in_stage
    import mtrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    input  logic        i_adv,
    output logic        o_fire,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;

    // The held item moves on whenever the result side can advance.
    assign o_fire  = r_valid && i_adv;
    assign o_stall = r_valid && !i_adv;
    assign o_item  = r_item;

    // Valid flag: reload whenever the held item leaves or the stage is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Payload is captured on each accepted item.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hdl/mtrc_capture.sv =====
// Byte position counter and header field capture registers.
module mtrc_capture
    import mtrc_pkg::*;
#(
    parameter  int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    localparam int PW               = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_data_byte,
    input  logic          i_is_last,
    output logic [PW-1:0] o_size,
    output t_capture      o_cap
);

    logic [PW-1:0] r_pos;
    t_capture      r_cap;
    t_capture      n_cap;

    // Merge the current byte into the captured fields by its position.
    always_comb begin
        n_cap = r_cap;
        if (r_pos == PW'(POS_TID_HI)) begin
            n_cap.trans_id[15:8] = i_data_byte;
        end
        if (r_pos == PW'(POS_TID_LO)) begin
            n_cap.trans_id[7:0] = i_data_byte;
        end
        if (r_pos == PW'(POS_LEN_HI)) begin
            n_cap.length[15:8] = i_data_byte;
        end
        if (r_pos == PW'(POS_LEN_LO)) begin
            n_cap.length[7:0] = i_data_byte;
        end
        if (r_pos == PW'(POS_FUNC)) begin
            n_cap.function_code = i_data_byte;
        end
        if (r_pos == PW'(POS_BYTE8)) begin
            n_cap.byte_eight = i_data_byte;
        end
    end

    // Packet size including the current byte, saturating at the limit.
    assign o_size = (r_pos < PW'(MAX_PACKET_BYTES)) ? r_pos + PW'(1)
                                                    : PW'(MAX_PACKET_BYTES);
    assign o_cap  = n_cap;

    // State clears after the final byte of a packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cap <= '0;
        end else if (i_fire) begin
            if (i_is_last) begin
                r_pos <= '0;
                r_cap <= '0;
            end else begin
                r_pos <= o_size;
                r_cap <= n_cap;
            end
        end
    end

endmodule

// ===== hdl/mtrc_check.sv =====
// Status evaluation and result output register.
module mtrc_check
    import mtrc_pkg::*;
#(
    parameter  int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    localparam int PW               = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_fire,
    input  t_item         i_item,
    input  logic [PW-1:0] i_size,
    input  t_capture      i_cap,
    output logic          o_valid,
    output logic [2:0]    o_status,
    output logic [7:0]    o_exception_code,
    output logic [7:0]    o_received_function,
    output logic [15:0]   o_received_trans_id
);

    t_status     n_status;
    logic [16:0] size_ext;
    logic [16:0] length_need;
    logic [16:0] count_need;
    logic        r_valid;
    t_status     r_status;
    t_capture    r_cap;
    logic        done;

    assign done        = i_fire && i_item.is_last;
    assign size_ext    = 17'(i_size);
    assign length_need = 17'(i_cap.length) + 17'(LENGTH_OFFSET);
    assign count_need  = 17'(i_cap.byte_eight) + 17'(COUNT_OFFSET);

    // Checks in priority order; the first failure gives the status.
    always_comb begin
        priority if (i_size < PW'(HEADER_MIN_BYTES)) begin
            n_status = ST_HEADER;
        end else if (i_size < PW'(PACKET_MIN_BYTES)) begin
            n_status = ST_INCOMPL;
        end else if (i_cap.function_code != i_item.expected_function) begin
            n_status = ((i_item.expected_function | EXC_FLAG) == i_cap.function_code)
                       ? ST_EXCEPT : ST_FUNC;
        end else if (size_ext < length_need) begin
            n_status = ST_LENGTH;
        end else if (i_item.check_trans_id
                     && (i_cap.trans_id != i_item.expected_trans_id)) begin
            n_status = ST_ID;
        end else if (i_item.check_byte_count && (size_ext != count_need)) begin
            n_status = ST_COUNT;
        end else begin
            n_status = ST_OK;
        end
    end

    // Result valid flag follows the output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= done;
        end
    end

    // Result payload loads on the final byte of a packet.
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_status <= n_status;
            r_cap    <= i_cap;
        end
    end

    assign o_valid             = r_valid;
    assign o_status            = r_status;
    assign o_exception_code    = r_cap.byte_eight;
    assign o_received_function = r_cap.function_code;
    assign o_received_trans_id = r_cap.trans_id;

endmodule

// ===== hdl/modbus_tcp_response_checker_unit.sv =====
// Top level of the Modbus TCP response checker.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   data_byte, is_last, expected fields, check enables
//   result   out        o_valid / i_stall   status, exception_code, received fields
//
// One byte is accepted every cycle unless a stalled result holds the pipeline; the byte counter and capture registers
// update in one pass between the input register and the result register.
// A result is loaded into the result register once its final byte leaves the input register.
// Reset is synchronous and active low; it clears the counter and captures.
// A stalled result holds the pipeline; a byte is still taken while the
// input register is free or moving on.
module modbus_tcp_response_checker_unit
    import mtrc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic [7:0]  i_expected_function,
    input  logic [15:0] i_expected_trans_id,
    input  logic        i_check_trans_id,
    input  logic        i_check_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic [7:0]  o_received_function,
    output logic [15:0] o_received_trans_id
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

    t_item         in_item;
    t_item         cur_item;
    logic          adv;
    logic          fire;
    logic [PW-1:0] size;
    t_capture      cap;

    // Pack the input fields.
    always_comb begin
        in_item.data_byte         = i_data_byte;
        in_item.is_last           = i_is_last;
        in_item.expected_function = i_expected_function;
        in_item.expected_trans_id = i_expected_trans_id;
        in_item.check_trans_id    = i_check_trans_id;
        in_item.check_byte_count  = i_check_byte_count;
    end

    // The pipeline advances while the result register is empty or drained.
    assign adv = !o_valid || !i_stall;

    mtrc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_adv   (adv),
        .o_fire  (fire),
        .o_item  (cur_item)
    );

    mtrc_capture #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (cur_item.data_byte),
        .i_is_last   (cur_item.is_last),
        .o_size      (size),
        .o_cap       (cap)
    );

    mtrc_check #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_adv               (adv),
        .i_fire              (fire),
        .i_item              (cur_item),
        .i_size              (size),
        .i_cap               (cap),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_exception_code    (o_exception_code),
        .o_received_function (o_received_function),
        .o_received_trans_id (o_received_trans_id)
    );

    // A final byte always produces a result in the next cycle.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && cur_item.is_last |=> o_valid)
        else $error("final byte did not produce a result");

    // After a final byte the counter restarts at the first byte.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && cur_item.is_last |=> size == PW'(1))
        else $error("byte counter did not restart after a final byte");

    // The packet size never exceeds the saturation limit and is never zero.
    a_size_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (size <= PW'(MAX_PACKET_BYTES)) && (size != '0))
        else $error("packet size out of range");

endmodule
